// ----- design/wsa_pkg.sv -----
package wsa_pkg;

    localparam int SAMPLE_W = 16;
    localparam int MEAN_W   = 16;
    localparam int FILL_W   = 6;

    typedef struct packed {
        logic busy;
        logic done;
    } wsa_div_status_t;

endpackage

// ----- design/windowed_sample_average_unit.sv -----
// Channel  | Direction | Handshake                   | Payload
// ---------+-----------+-----------------------------+------------------
// sample   | in        | sample_valid / sample_stall | sample
// result   | out       | result_valid / result_stall | mean, fill_count
//
// After transfer a sample updates the window total, then the restoring divider
// is started and gives one quotient bit per cycle; the result register loads
// the quotient once that register is free. One sample is in work at a time.
// The result register lets the next sample transfer while a result waits.
// Reset is asynchronous, active low; the window store itself is not cleared,
// entries not yet written are masked by the fill count.
module windowed_sample_average_unit #(
    parameter int WINDOW_DEPTH = 32,
    parameter int SAMPLE_BITS  = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          sample_valid,
    output logic                          sample_stall,
    input  logic [wsa_pkg::SAMPLE_W-1:0]  sample,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [wsa_pkg::MEAN_W-1:0]    mean,
    output logic [wsa_pkg::FILL_W-1:0]    fill_count
);
    import wsa_pkg::*;

    localparam int SW = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
    localparam int CW = $clog2(WINDOW_DEPTH + 1);
    localparam int PW = $clog2(WINDOW_DEPTH);
    localparam int TW = SW + CW;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SUM,
        ST_START,
        ST_DIV
    } state_t;

    state_t          state_reg;
    logic [SW-1:0]   mem [WINDOW_DEPTH];
    logic [SW-1:0]   old_reg;
    logic [SW-1:0]   sample_reg;
    logic            evict_reg;
    logic [PW-1:0]   ptr_reg;
    logic [CW-1:0]   count_reg;
    logic [TW-1:0]   total_reg;
    logic [TW-1:0]   total_next;
    logic            result_valid_reg;
    logic [MEAN_W-1:0] mean_reg;
    logic [FILL_W-1:0] fill_reg;

    logic            sample_xfer;
    logic            out_free;
    logic            result_load;
    logic            div_start;
    logic [TW-1:0]   div_quotient;
    wsa_div_status_t div_status;
    logic [SW-1:0]   sample_m;

    assign sample_m     = sample[SW-1:0];
    assign sample_stall = (state_reg != ST_IDLE);
    assign sample_xfer  = sample_valid && !sample_stall;
    assign out_free     = !result_valid_reg || !result_stall;
    assign result_load  = (state_reg == ST_DIV) && div_status.done && out_free;
    assign div_start    = (state_reg == ST_START);
    assign total_next   = total_reg - (evict_reg ? TW'(old_reg) : '0) + TW'(sample_reg);

    wsa_divider #(
        .DIVIDEND_W (TW),
        .DIVISOR_W  (CW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (total_reg),
        .divisor  (count_reg),
        .quotient (div_quotient),
        .status   (div_status)
    );

    // read-before-write: old entry comes out as the new one goes in
    always_ff @(posedge clk)
    begin
        if (sample_xfer)
        begin
            old_reg      <= mem[ptr_reg];
            mem[ptr_reg] <= sample_m;
            sample_reg   <= sample_m;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            ptr_reg          <= '0;
            count_reg        <= '0;
            total_reg        <= '0;
            evict_reg        <= 1'b0;
            result_valid_reg <= 1'b0;
            mean_reg         <= '0;
            fill_reg         <= '0;
        end
        else
        begin
            if (result_load)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_valid_reg && !result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (sample_xfer)
                    begin
                        evict_reg <= (count_reg == CW'(WINDOW_DEPTH));
                        ptr_reg   <= (ptr_reg == PW'(WINDOW_DEPTH - 1)) ? '0 : ptr_reg + 1'b1;
                        if (count_reg != CW'(WINDOW_DEPTH))
                        begin
                            count_reg <= count_reg + 1'b1;
                        end
                        state_reg <= ST_SUM;
                    end
                end
                ST_SUM:
                begin
                    total_reg <= total_next;
                    state_reg <= ST_START;
                end
                ST_START:
                begin
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    if (result_load)
                    begin
                        mean_reg  <= MEAN_W'(div_quotient);
                        fill_reg  <= FILL_W'(count_reg);
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign result_valid = result_valid_reg;
    assign mean         = mean_reg;
    assign fill_count   = fill_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(WINDOW_DEPTH))
        else $error("fill count above window depth");

    a_fill_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg < CW'(WINDOW_DEPTH)) |-> (CW'(ptr_reg) == count_reg))
        else $error("write pointer out of step with fill count");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        sample_xfer |=> sample_stall)
        else $error("second sample taken while one is in work");

    a_div_idle_on_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_status.busy)
        else $error("divider restarted while busy");

    a_load_needs_quotient: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DIV) && (state_reg != $past(state_reg)) && $past(rst_n))
        |-> !div_status.done)
        else $error("stale quotient seen at divide start");
`endif

endmodule

// ----- design/wsa_divider.sv -----
module wsa_divider #(
    parameter int DIVIDEND_W = 21,
    parameter int DIVISOR_W  = 6
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [DIVIDEND_W-1:0]    dividend,
    input  logic [DIVISOR_W-1:0]     divisor,
    output logic [DIVIDEND_W-1:0]    quotient,
    output wsa_pkg::wsa_div_status_t status
);
    import wsa_pkg::*;

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVIDEND_W-1:0] quo_next;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  rem_next;
    logic [DIVISOR_W-1:0]  dvs_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic [DIVISOR_W:0]    shifted;
    logic [DIVISOR_W:0]    diff;
    logic                  fits;

    // one restoring step per cycle
    always_comb
    begin
        shifted  = {rem_reg, quo_reg[DIVIDEND_W-1]};
        diff     = shifted - {1'b0, dvs_reg};
        fits     = (shifted >= {1'b0, dvs_reg});
        quo_next = {quo_reg[DIVIDEND_W-2:0], fits};
        rem_next = fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(DIVIDEND_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

// ----- sim/tb_windowed_sample_average_unit.sv -----
module tb_windowed_sample_average_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import wsa_pkg::*;

    localparam int WIN_DEPTH   = 32;
    localparam int CYCLE_LIMIT = 900000;
    localparam int RAND_ITEMS  = 1150;
    localparam int DRAIN_WAIT  = 40;

    typedef struct packed {
        logic [MEAN_W-1:0] mean;
        logic [FILL_W-1:0] fill;
    } avg_result_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                typed;
        avg_result_t         want;
    } dir_row_t;

    localparam int DIR_ROWS = 24;

    // typed rows: fresh window after reset
    dir_row_t dir_rows [DIR_ROWS] = '{
        '{16'hFFFF, 1'b1, '{16'hFFFF, 6'd1}},
        '{16'h0000, 1'b1, '{16'h7FFF, 6'd2}},
        '{16'h0001, 1'b1, '{16'h5555, 6'd3}},
        '{16'h0000, 1'b1, '{16'h4000, 6'd4}},
        '{16'h8000, 1'b0, '{16'h0000, 6'd0}},
        '{16'h7FFF, 1'b0, '{16'h0000, 6'd0}},
        '{16'hAAAA, 1'b0, '{16'h0000, 6'd0}},
        '{16'h5555, 1'b0, '{16'h0000, 6'd0}},
        '{16'hFFFE, 1'b0, '{16'h0000, 6'd0}},
        '{16'h0002, 1'b0, '{16'h0000, 6'd0}},
        '{16'h00FF, 1'b0, '{16'h0000, 6'd0}},
        '{16'hFF00, 1'b0, '{16'h0000, 6'd0}},
        '{16'h0F0F, 1'b0, '{16'h0000, 6'd0}},
        '{16'hF0F0, 1'b0, '{16'h0000, 6'd0}},
        '{16'hFFFF, 1'b0, '{16'h0000, 6'd0}},
        '{16'hFFFF, 1'b0, '{16'h0000, 6'd0}},
        '{16'hFFFF, 1'b0, '{16'h0000, 6'd0}},
        '{16'hFFFF, 1'b0, '{16'h0000, 6'd0}},
        '{16'hFFFF, 1'b0, '{16'h0000, 6'd0}},
        '{16'hFFFF, 1'b0, '{16'h0000, 6'd0}},
        '{16'hFFFF, 1'b0, '{16'h0000, 6'd0}},
        '{16'hFFFF, 1'b0, '{16'h0000, 6'd0}},
        '{16'hFFFF, 1'b0, '{16'h0000, 6'd0}},
        '{16'hFFFF, 1'b0, '{16'h0000, 6'd0}}
    };

    logic                clk;
    logic                rst_n        = 1'b0;
    logic                sample_valid = 1'b0;
    logic                sample_stall;
    logic [SAMPLE_W-1:0] sample       = '0;
    logic                result_valid;
    logic                result_stall = 1'b0;
    logic [MEAN_W-1:0]   mean;
    logic [FILL_W-1:0]   fill_count;

    // predictor state
    logic [SAMPLE_W-1:0] win_samples [WIN_DEPTH];
    logic [4:0]          win_wr;
    logic [5:0]          win_count;
    logic [20:0]         win_total;

    avg_result_t pending_means [$];
    int          mismatch_cnt = 0;
    int          cycle_cnt    = 0;
    int          stall_run    = 0;
    bit          quiet        = 1'b0;

    windowed_sample_average_unit #(
        .WINDOW_DEPTH (WIN_DEPTH),
        .SAMPLE_BITS  (SAMPLE_W)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .mean         (mean),
        .fill_count   (fill_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic avg_result_t window_mean_step(input logic [SAMPLE_W-1:0] s);
        avg_result_t r;
        win_total = win_total - 21'(win_samples[win_wr]) + 21'(s);
        win_samples[win_wr] = s;
        win_wr = (win_wr == 5'(WIN_DEPTH - 1)) ? 5'd0 : win_wr + 5'd1;
        if (win_count < 6'(WIN_DEPTH))
            win_count = win_count + 6'd1;
        r.mean = MEAN_W'(win_total / 21'(win_count));
        r.fill = win_count;
        return r;
    endfunction

    function automatic int idle_len(input int p_none);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < p_none)
            return 0;
        if (r < p_none + (100 - p_none) * 2 / 3)
            return $urandom_range(1, 4);
        if (r < 97)
            return $urandom_range(5, 30);
        return $urandom_range(40, 80);
    endfunction

    task automatic send_sample(input logic [SAMPLE_W-1:0] s);
        int gap;
        gap = idle_len(55);
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample       <= s;
        do
            @(posedge clk);
        while (sample_stall !== 1'b0);
    endtask

    task automatic wait_drained();
        while (pending_means.size() != 0)
            @(posedge clk);
    endtask

    // result side: check, then pick next stall
    always @(posedge clk)
    begin
        avg_result_t want;
        if (rst_n)
        begin
            if (result_valid === 1'b1 && result_stall === 1'b0)
            begin
                if (pending_means.size() == 0)
                begin
                    if (mismatch_cnt < 10)
                        $display("unexpected result transfer: mean=%h fill=%0d",
                                 mean, fill_count);
                    mismatch_cnt++;
                end
                else
                begin
                    want = pending_means.pop_front();
                    if (mean !== want.mean || fill_count !== want.fill)
                    begin
                        if (mismatch_cnt < 10)
                            $display("mismatch: mean exp %h got %h, fill exp %0d got %0d",
                                     want.mean, mean, want.fill, fill_count);
                        mismatch_cnt++;
                    end
                end
            end
            if (stall_run == 0)
                stall_run = idle_len(75);
            if (stall_run > 0)
            begin
                result_stall <= 1'b1;
                stall_run--;
            end
            else
                result_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        avg_result_t r;
        int          sent;
        int          mode;
        int          len;
        bit          drained_once;
        logic [SAMPLE_W-1:0] s;

        foreach (win_samples[k])
            win_samples[k] = '0;
        win_wr       = '0;
        win_count    = '0;
        win_total    = '0;
        sent         = 0;
        drained_once = 1'b0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            send_sample(dir_rows[i].sample);
            r = window_mean_step(dir_rows[i].sample);
            pending_means.push_back(dir_rows[i].typed ? dir_rows[i].want : r);
        end

        sample_valid <= 1'b0;
        wait_drained();

        while (sent < RAND_ITEMS)
        begin
            mode  = $urandom_range(0, 5);
            len   = $urandom_range(8, 48);
            quiet = ($urandom_range(0, 4) == 0);
            if (!drained_once && sent >= RAND_ITEMS / 2)
            begin
                sample_valid <= 1'b0;
                wait_drained();
                drained_once = 1'b1;
            end
            for (int j = 0; j < len; j++)
            begin
                case (mode)
                    0: s = SAMPLE_W'($urandom);
                    1: s = '1;
                    2: s = '0;
                    3: s = SAMPLE_W'($urandom_range(0, 15));
                    4: s = $urandom_range(0, 1) ? '1 : '0;
                    default: s = SAMPLE_W'($urandom_range(16'hFF00, 16'hFFFF));
                endcase
                send_sample(s);
                pending_means.push_back(window_mean_step(s));
                sent++;
            end
        end

        sample_valid <= 1'b0;
        quiet = 1'b0;
        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);

        if (mismatch_cnt == 0 && pending_means.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- files.f -----
design/wsa_pkg.sv
design/wsa_divider.sv
design/windowed_sample_average_unit.sv
sim/tb_windowed_sample_average_unit.sv
